// ===== hw/rtl/lphs_pkg.sv =====
// ============================================================================
// lphs_pkg: shared constants and types for the linear probe hash set
// Field widths, status and request codes, hash constants and FSM states.
// ============================================================================
package lphs_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 48;

  localparam int REQ_W    = 1;
  localparam int KEY_W    = 48;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 10;

  localparam logic [63:0] HASH_PRIME = 64'd26544357617;
  localparam int FILL_NUM = 3;
  localparam int FILL_DEN = 4;

  localparam logic [REQ_W-1:0] REQ_INSERT = 1'b0;
  localparam logic [REQ_W-1:0] REQ_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_READ     = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_DONE
  } lphs_state_t;

endpackage

// ===== hw/rtl/lphs_ifs.sv =====
// ============================================================================
// lphs_ifs: request and result channels of the linear probe hash set
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
interface lphs_in_if;
  logic                         valid;
  logic                         ready;
  logic [lphs_pkg::REQ_W-1:0]   req_type;
  logic [lphs_pkg::KEY_W-1:0]   key;
  logic [lphs_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, req_type, key, slot, input ready);
  modport sink   (input valid, req_type, key, slot, output ready);
endinterface

interface lphs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lphs_pkg::STATUS_W-1:0] status;
  logic [lphs_pkg::SLOT_W-1:0]   slot_out;
  logic [lphs_pkg::KEY_W-1:0]    key_out;
  logic [lphs_pkg::COUNT_W-1:0]  stored_count;

  modport source (output valid, status, slot_out, key_out, stored_count, input ready);
  modport sink   (input valid, status, slot_out, key_out, stored_count, output ready);
endinterface

// ===== hw/rtl/linear_probe_hash_set.sv =====
// ============================================================================
// linear_probe_hash_set: open-addressing hash set with linear probing
// Inserts nonzero keys into a single-port key memory; reads back one slot.
// ============================================================================
// After reset the block sweeps the key memory to zero, one slot per cycle, and
// accepts no request until the sweep is done. It then handles one request at a
// time. A read or an insert visits the key memory one slot at a time: first
// the address state, then the check of the registered data. An insert probes
// successive slots until it finds an empty slot or its own key; a read visits
// only the slot it names, and a null key or a full table skips the memory. The
// probe loop over the single memory port sets the rate. A finished result sits
// in an output register, so the next request is accepted while it waits.
// CAPACITY must be a power of two.
module linear_probe_hash_set #(
  parameter int CAPACITY = lphs_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lphs_pkg::KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lphs_in_if.sink           in_ch,
  lphs_out_if.source        out_ch
);
  import lphs_pkg::*;

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int FILL_LIMIT = (CAPACITY * FILL_NUM) / FILL_DEN;
  localparam int CNT_W      = $clog2(FILL_LIMIT + 1);
  localparam logic [IDX_W-1:0] PRIME_LO = HASH_PRIME[IDX_W-1:0];
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  lphs_state_t state_r, state_nxt;

  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_slot_r, res_slot_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [KEY_BITS-1:0] rd_data_r;
  logic                mem_we;
  logic [KEY_BITS-1:0] mem_wdata;

  logic                in_ready;
  logic                in_acc;
  logic                out_load;
  logic                slot_empty;
  logic                key_hit;
  logic                table_full;

  logic [KEY_BITS+KEY_W-1:0]  key_ext;
  logic [KEY_BITS-1:0]        key_m;
  logic [IDX_W+SLOT_W-1:0]    slot_ext;
  logic [IDX_W-1:0]           slot_idx;
  logic [2*IDX_W-1:0]         hash_prod;
  logic [SLOT_W+IDX_W-1:0]    res_slot_ext;
  logic [KEY_W+KEY_BITS-1:0]  res_key_ext;
  logic [COUNT_W+CNT_W-1:0]   count_ext;

  assign key_ext   = {{KEY_BITS{1'b0}}, in_ch.key};
  assign key_m     = key_ext[KEY_BITS-1:0];
  assign slot_ext  = {{IDX_W{1'b0}}, in_ch.slot};
  assign slot_idx  = slot_ext[IDX_W-1:0];
  assign hash_prod = key_m[IDX_W-1:0] * PRIME_LO;

  assign in_acc     = in_ch.valid && in_ready;
  assign slot_empty = (rd_data_r == '0);
  assign key_hit    = (rd_data_r == key_r);
  assign table_full = (count_r >= CNT_W'(FILL_LIMIT));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (idx_r == LAST_IDX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_READ) state_nxt = S_PROBE;
          else if (key_m == '0 || table_full) state_nxt = S_DONE;
          else state_nxt = S_PROBE;
        end
      end
      S_PROBE: state_nxt = S_CHECK;
      S_CHECK: begin
        if (req_r == REQ_READ || slot_empty || key_hit) state_nxt = S_DONE;
        else state_nxt = S_PROBE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = key_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE:  in_ready = 1'b1;
      S_PROBE: ;
      S_CHECK: mem_we = (req_r == REQ_INSERT) && slot_empty;
      S_DONE:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    case (state_r)
      S_CLEAR: idx_nxt = idx_r + 1'b1;
      S_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_ch.req_type;
          key_nxt      = key_m;
          res_slot_nxt = '0;
          res_key_nxt  = '0;
          if (in_ch.req_type == REQ_READ) begin
            idx_nxt = slot_idx;
          end else if (key_m == '0) begin
            res_status_nxt = STATUS_NULL;
          end else if (table_full) begin
            res_status_nxt = STATUS_FULL;
          end else begin
            idx_nxt = hash_prod[IDX_W-1:0];
          end
        end
      end
      S_CHECK: begin
        res_slot_nxt = idx_r;
        if (req_r == REQ_READ) begin
          res_status_nxt = STATUS_READ;
          res_key_nxt    = rd_data_r;
        end else if (slot_empty) begin
          res_status_nxt = STATUS_INSERTED;
          res_key_nxt    = key_r;
          count_nxt      = count_r + 1'b1;
        end else if (key_hit) begin
          res_status_nxt = STATUS_PRESENT;
          res_key_nxt    = key_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign res_slot_ext = {{SLOT_W{1'b0}}, res_slot_r};
  assign res_key_ext  = {{KEY_W{1'b0}}, res_key_r};
  assign count_ext    = {{COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_ext[SLOT_W-1:0];
      out_key_r    <= res_key_ext[KEY_W-1:0];
      out_count_r  <= count_ext[COUNT_W-1:0];
    end
  end

  // key memory with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) key_mem[idx_r] <= mem_wdata;
    rd_data_r <= key_mem[idx_r];
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.slot_out     = out_slot_r;
  assign out_ch.key_out      = out_key_r;
  assign out_ch.stored_count = out_count_r;

endmodule

// ===== hw/rtl/lphs_checker.sv =====
// ============================================================================
// lphs_checker: port-level checks for the linear probe hash set
// Watches the request and result channels; bound to the top level.
// ============================================================================
module lphs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lphs_pkg::STATUS_W-1:0] out_status,
  input logic [lphs_pkg::SLOT_W-1:0]   out_slot_out,
  input logic [lphs_pkg::KEY_W-1:0]    out_key_out,
  input logic [lphs_pkg::COUNT_W-1:0]  out_stored_count
);
  import lphs_pkg::*;

  // clearing pass starts right after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("request or result channel active right after reset");

  // one transaction in flight inside the block
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NULL || out_status == STATUS_FULL)
    |-> out_slot_out == '0 && out_key_out == '0)
    else $error("null or full result carries slot or key");

  a_stored_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_INSERTED || out_status == STATUS_PRESENT)
    |-> out_key_out != '0 && out_stored_count != '0)
    else $error("insert result with empty key or zero count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_out) && $stable(out_key_out) && $stable(out_stored_count))
    else $error("stalled result changed");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_slot_out     (out_ch.slot_out),
  .out_key_out      (out_ch.key_out),
  .out_stored_count (out_ch.stored_count)
);

// ===== dv/tb.sv =====
// ============================================================================
// tb: self-checking testbench for linear_probe_hash_set
// Drives insert and slot-read transactions through valid/ready channels. A
// shadow copy of the key table predicts every response. Stimulus covers
// directed corner cases, random mixes under four idle/stall profiles, and a
// closing mix of inserts and slot reads.
// ============================================================================
import lphs_pkg::*;

typedef struct packed {
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] slot;
} hash_req_t;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [KEY_W-1:0]    key_out;
  logic [COUNT_W-1:0]  stored_count;
} hash_rsp_t;

class hash_set_tracker;
  logic [KEY_W-1:0] slots [CAPACITY_DEF];
  int unsigned      key_count;
  hash_rsp_t        pending_rsp [$];
  int unsigned      mismatches;
  int unsigned      n_inserted, n_present, n_null, n_full, n_read;

  function new();
    foreach (slots[i]) slots[i] = '0;
    key_count  = 0;
    mismatches = 0;
    n_inserted = 0;
    n_present  = 0;
    n_null     = 0;
    n_full     = 0;
    n_read     = 0;
  endfunction

  function logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] k);
    logic [63:0] prod;
    prod = {{(64-KEY_W){1'b0}}, k} * HASH_PRIME;
    return prod[SLOT_W-1:0];
  endfunction

  function void accept_request(input hash_req_t r);
    hash_rsp_t        rsp;
    logic [SLOT_W-1:0] idx;
    bit               done;
    int               p;
    rsp = '0;
    if (r.req_type == REQ_READ) begin
      rsp.status   = STATUS_READ;
      rsp.slot_out = r.slot;
      rsp.key_out  = slots[r.slot];
    end else if (r.key == '0) begin
      rsp.status = STATUS_NULL;
    end else if (key_count >= CAPACITY_DEF * FILL_NUM / FILL_DEN) begin
      rsp.status = STATUS_FULL;
    end else begin
      idx  = home_slot(r.key);
      done = 1'b0;
      rsp.status = STATUS_FULL;
      for (p = 0; p < CAPACITY_DEF && !done; p++) begin
        if (slots[idx] == '0) begin
          slots[idx] = r.key;
          key_count++;
          rsp.status   = STATUS_INSERTED;
          rsp.slot_out = idx;
          rsp.key_out  = r.key;
          done = 1'b1;
        end else if (slots[idx] == r.key) begin
          rsp.status   = STATUS_PRESENT;
          rsp.slot_out = idx;
          rsp.key_out  = r.key;
          done = 1'b1;
        end else begin
          idx = idx + 1'b1;
        end
      end
    end
    rsp.stored_count = key_count[COUNT_W-1:0];
    case (rsp.status)
      STATUS_INSERTED: n_inserted++;
      STATUS_PRESENT:  n_present++;
      STATUS_NULL:     n_null++;
      STATUS_FULL:     n_full++;
      default:         n_read++;
    endcase
    pending_rsp.push_back(rsp);
  endfunction

  function void check_response(input hash_rsp_t got);
    hash_rsp_t exp;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: response with none pending: status=%0d slot=%0d key=%h count=%0d",
                 got.status, got.slot_out, got.key_out, got.stored_count);
      return;
    end
    exp = pending_rsp.pop_front();
    if (got.status !== exp.status || got.slot_out !== exp.slot_out ||
        got.key_out !== exp.key_out || got.stored_count !== exp.stored_count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: expected status=%0d slot=%0d key=%h count=%0d",
                 exp.status, exp.slot_out, exp.key_out, exp.stored_count);
        $display("       actual   status=%0d slot=%0d key=%h count=%0d",
                 got.status, got.slot_out, got.key_out, got.stored_count);
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int FILL_LIMIT  = CAPACITY_DEF * FILL_NUM / FILL_DEN;

  logic clk;
  logic rst_n;

  lphs_in_if  in_if ();
  lphs_out_if out_if ();

  linear_probe_hash_set DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  hash_set_tracker  sb;
  logic [KEY_W-1:0] key_pool [$];
  int               send_idle_pct;
  int               recv_stall_pct;
  int               idle_cycles;
  int unsigned      n_sent;
  hash_rsp_t        got_rsp;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_rsp.status       = out_if.status;
      got_rsp.slot_out     = out_if.slot_out;
      got_rsp.key_out      = out_if.key_out;
      got_rsp.stored_count = out_if.stored_count;
      sb.check_response(got_rsp);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("linear_probe_hash_set test failed");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    if ($urandom_range(9) == 0) k = KEY_W'($urandom_range(1, 1023));
    else k = KEY_W'({$urandom, $urandom});
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // starts and ends at a falling edge; valid stays high between back-to-back items
  task automatic send_req(input hash_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= r.req_type;
    in_if.key      <= r.key;
    in_if.slot     <= r.slot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.accept_request(r);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_insert(input logic [KEY_W-1:0] k);
    hash_req_t r;
    r.req_type = REQ_INSERT;
    r.key      = k;
    r.slot     = SLOT_W'($urandom);
    if (k != '0) key_pool.push_back(k);
    send_req(r);
  endtask

  task automatic send_read(input logic [SLOT_W-1:0] s);
    hash_req_t r;
    r.req_type = REQ_READ;
    r.key      = fresh_key();
    r.slot     = s;
    send_req(r);
  endtask

  task automatic random_item();
    int               pick;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(1)) send_read(SLOT_W'($urandom_range(1023)));
      else send_read(sb.home_slot(pool_key()));
    end else if (pick < 50) begin
      send_insert(pool_key());
    end else if (pick < 62) begin
      // same home slot as a stored key: forces a probe chain
      k = pool_key() + (KEY_W'($urandom_range(1, 63)) << SLOT_W);
      send_insert(k);
    end else if (pick < 66) begin
      send_insert('0);
    end else begin
      send_insert(fresh_key());
    end
  endtask

  initial begin
    int               send_idle_tab  [4];
    int               recv_stall_tab [4];
    logic [KEY_W-1:0] wrap_key;
    int               ph;

    send_idle_tab  = '{0, 52, 0, 25};
    recv_stall_tab = '{0, 0, 52, 25};
    sb = new();
    n_sent         = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.req_type = REQ_INSERT;
    in_if.key      = '0;
    in_if.slot     = '0;
    out_if.ready   = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    wrap_key = 1;
    while (sb.home_slot(wrap_key) != SLOT_W'(CAPACITY_DEF - 1)) wrap_key++;
    send_read('0);
    send_read('1);
    send_insert('0);
    send_insert('1);
    send_insert(KEY_W'(1));
    send_insert(KEY_W'(1));
    send_insert({1'b1, {(KEY_W-1){1'b0}}});
    send_insert(wrap_key);
    send_insert(wrap_key + (KEY_W'(1) << SLOT_W));
    send_insert(wrap_key + (KEY_W'(2) << SLOT_W));
    send_insert(wrap_key + (KEY_W'(2) << SLOT_W));
    send_insert(wrap_key);
    send_read(SLOT_W'(CAPACITY_DEF - 1));
    send_read('0);
    send_read(SLOT_W'(1));
    send_read(sb.home_slot(KEY_W'(1)));
    send_read(sb.home_slot('1));
    send_insert('1);
    send_insert('0);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle_tab[ph];
      recv_stall_pct = recv_stall_tab[ph];
      repeat (105) random_item();
    end

    // closing mix of inserts and slot reads
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    send_insert(fresh_key());
    send_insert(pool_key());
    send_insert('0);
    send_insert('1);
    repeat (6) send_read(SLOT_W'($urandom_range(1023)));
    in_if.valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions: %0d inserted, %0d present, %0d null, %0d full, %0d reads",
             n_sent, sb.n_inserted, sb.n_present, sb.n_null, sb.n_full, sb.n_read);
    $display("Table held %0d keys (limit %0d) after directed cases and four idle/stall profiles",
             sb.key_count, FILL_LIMIT);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("linear_probe_hash_set test passed");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending_rsp.size());
      $display("linear_probe_hash_set test failed");
    end
    $finish;
  end
endmodule
